// File: hdl/wpid_pkg.sv
package wpid_pkg;

    localparam int NUM_WHEELS_DEF = 4;
    localparam int WHEEL_W        = 2;
    localparam int DATA_W         = 32;
    localparam int TDATA_W        = 2 * DATA_W;
    localparam int GAIN_W         = 24;
    localparam int SCALE_W        = 32;
    localparam int LIM_W          = 31;
    localparam int FRAC_GAIN      = 12;
    localparam int LIMQ_W         = LIM_W + FRAC_GAIN;
    localparam int SUM_W          = 48;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_LIMIT = 3'd4;

    localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = 24'd491520;
    localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST  = 24'd120832;
    localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST  = 24'd164;
    localparam logic [SCALE_W-1:0] SPEED_SCALE_RST = 32'd5679700;
    localparam logic [LIM_W-1:0]   INTEG_LIMIT_RST = 31'd67108864;

    typedef struct packed {
        logic busy;
        logic rem_nonzero;
    } div_status_t;

endpackage

// File: hdl/wpid_div.sv
module wpid_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [wpid_pkg::LIMQ_W-1:0] dividend,
    input  logic [wpid_pkg::GAIN_W-1:0] divisor,
    output logic [wpid_pkg::LIMQ_W-1:0] quotient,
    output wpid_pkg::div_status_t       status
);
    import wpid_pkg::*;

    localparam int CNT_W = $clog2(LIMQ_W + 1);

    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic [LIMQ_W-1:0] quo_reg;
    logic [GAIN_W-1:0] rem_reg;
    logic [GAIN_W:0]   shifted;
    logic [GAIN_W:0]   trial;
    logic              fits;

    assign shifted = {rem_reg, quo_reg[LIMQ_W-1]};
    assign trial   = shifted - {1'b0, divisor};
    assign fits    = (shifted >= {1'b0, divisor});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(LIMQ_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[LIMQ_W-2:0], fits};
            rem_reg <= fits ? trial[GAIN_W-1:0] : shifted[GAIN_W-1:0];
        end
    end

    assign quotient           = quo_reg;
    assign status.busy        = busy_reg;
    assign status.rem_nonzero = (rem_reg != '0);

endmodule

// File: hdl/wheel_speed_pid_unit.sv
// One item at a time: s_tready is high only in the idle state, until the previous result
// is loaded for output. For a wheel in range, the 43-step restoring divider derives the
// integral clamp bound; the shared 33x33 multiplier is used five times per item.
// Reset: synchronous, active-low aresetn restores the config registers to their defaults
// and marks every wheel entry empty, so it reads as zero until first written; no clear pass.
module wheel_speed_pid_unit #(
    parameter int NUM_WHEELS = wpid_pkg::NUM_WHEELS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [wpid_pkg::TDATA_W-1:0]    s_tdata,   // encoder_count, target_speed
    input  logic [wpid_pkg::WHEEL_W-1:0]    s_tuser,   // wheel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [wpid_pkg::TDATA_W-1:0]    m_tdata,   // drive, measured_speed
    output logic [wpid_pkg::WHEEL_W-1:0]    m_tuser,   // wheel_out
    input  logic                            cfg_we,
    input  logic [wpid_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [wpid_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import wpid_pkg::*;

    localparam int AW      = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;
    localparam int WEXT_W  = 5;
    localparam int ENTRY_W = DATA_W + SUM_W + DATA_W;
    localparam int MUL_W   = DATA_W + 1;
    localparam int ACC_W   = 60;
    localparam int SPLIT   = SUM_W / 2;
    localparam int CMP_W   = SUM_W + 2;
    localparam int SPD_SH  = 8;

    localparam logic [WEXT_W-1:0] WHEEL_CNT = WEXT_W'(NUM_WHEELS);

    localparam logic signed [63:0]    S32_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0]    S32_MIN = 64'shFFFF_FFFF_8000_0000;
    localparam logic signed [SUM_W:0] S48_MAX = {2'b00, {(SUM_W - 1){1'b1}}};
    localparam logic signed [SUM_W:0] S48_MIN = {2'b11, {(SUM_W - 1){1'b0}}};

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_LOAD  = 4'd1;
    localparam logic [3:0] ST_MSPD  = 4'd2;
    localparam logic [3:0] ST_SPD   = 4'd3;
    localparam logic [3:0] ST_ERR   = 4'd4;
    localparam logic [3:0] ST_SUM   = 4'd5;
    localparam logic [3:0] ST_KP    = 4'd6;
    localparam logic [3:0] ST_KD    = 4'd7;
    localparam logic [3:0] ST_CLAMP = 4'd8;
    localparam logic [3:0] ST_KI0   = 4'd9;
    localparam logic [3:0] ST_KI1   = 4'd10;
    localparam logic [3:0] ST_KIH   = 4'd11;
    localparam logic [3:0] ST_WB    = 4'd12;
    localparam logic [3:0] ST_OUT   = 4'd13;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
        logic signed [DATA_W-1:0] r;
        if (x > S32_MAX) begin
            r = S32_MAX[DATA_W-1:0];
        end else if (x < S32_MIN) begin
            r = S32_MIN[DATA_W-1:0];
        end else begin
            r = x[DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [SUM_W-1:0] sat48(input logic signed [SUM_W:0] x);
        logic signed [SUM_W-1:0] r;
        if (x > S48_MAX) begin
            r = S48_MAX[SUM_W-1:0];
        end else if (x < S48_MIN) begin
            r = S48_MIN[SUM_W-1:0];
        end else begin
            r = x[SUM_W-1:0];
        end
        return r;
    endfunction

    logic [GAIN_W-1:0]  prop_gain_reg;
    logic [GAIN_W-1:0]  integ_gain_reg;
    logic [GAIN_W-1:0]  deriv_gain_reg;
    logic [SCALE_W-1:0] speed_scale_reg;
    logic [LIM_W-1:0]   integ_limit_reg;

    logic [3:0]                state_reg;
    logic [3:0]                state_next;
    logic [WHEEL_W-1:0]        wheel_reg;
    logic [AW-1:0]             addr_reg;
    logic [DATA_W-1:0]         count_reg;
    logic signed [DATA_W-1:0]  target_reg;
    logic [DATA_W-1:0]         pc_reg;
    logic signed [SUM_W-1:0]   es_reg;
    logic signed [DATA_W-1:0]  pe_reg;
    logic signed [DATA_W-1:0]  speed_reg;
    logic signed [DATA_W-1:0]  err_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [DATA_W-1:0]  drive_reg;
    logic signed [2*MUL_W-1:0] prod_reg;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;

    logic [ENTRY_W-1:0]    mem [NUM_WHEELS];
    logic [ENTRY_W-1:0]    rd_data_reg;
    logic                  rd_valid_reg;
    logic [NUM_WHEELS-1:0] valid_reg;

    logic                  m_tvalid_reg;
    logic [TDATA_W-1:0]    m_tdata_reg;
    logic [WHEEL_W-1:0]    m_tuser_reg;

    logic [WEXT_W-1:0]     wheel_ext;
    logic [AW-1:0]         s_addr;
    logic                  in_range;
    logic                  accept;
    logic                  out_load;
    logic                  wr_en;
    logic [DATA_W-1:0]     diff;
    logic signed [MUL_W-1:0] derr;
    logic signed [MUL_W:0] err_wide;
    logic signed [SUM_W:0] sum_wide;
    logic [LIMQ_W-1:0]     quotient;
    div_status_t           div_status;
    logic [LIMQ_W:0]       thr;
    logic signed [CMP_W-1:0] sum_x;
    logic signed [CMP_W-1:0] thr_x;
    logic signed [CMP_W-1:0] q_x;

    assign wheel_ext = WEXT_W'(s_tuser);
    assign s_addr    = wheel_ext[AW-1:0];
    assign in_range  = (wheel_ext < WHEEL_CNT);
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_load  = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);
    assign wr_en     = (state_reg == ST_WB);

    assign diff     = count_reg - pc_reg;
    assign derr     = MUL_W'(err_reg) - MUL_W'(pe_reg);
    assign err_wide = (MUL_W + 1)'(target_reg) - (MUL_W + 1)'(speed_reg);
    assign sum_wide = (SUM_W + 1)'(es_reg) + (SUM_W + 1)'(err_reg);

    assign thr   = (LIMQ_W + 1)'(quotient) + (LIMQ_W + 1)'(div_status.rem_nonzero);
    assign sum_x = CMP_W'(sum_reg);
    assign thr_x = $signed(CMP_W'(thr));
    assign q_x   = $signed(CMP_W'(quotient));

    wpid_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept && in_range),
        .dividend ({integ_limit_reg, {FRAC_GAIN{1'b0}}}),
        .divisor  (integ_gain_reg),
        .quotient (quotient),
        .status   (div_status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg   <= PROP_GAIN_RST;
            integ_gain_reg  <= INTEG_GAIN_RST;
            deriv_gain_reg  <= DERIV_GAIN_RST;
            speed_scale_reg <= SPEED_SCALE_RST;
            integ_limit_reg <= INTEG_LIMIT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PROP_GAIN:   prop_gain_reg   <= cfg_wdata[GAIN_W-1:0];
                REG_INTEG_GAIN:  integ_gain_reg  <= cfg_wdata[GAIN_W-1:0];
                REG_DERIV_GAIN:  deriv_gain_reg  <= cfg_wdata[GAIN_W-1:0];
                REG_SPEED_SCALE: speed_scale_reg <= cfg_wdata[SCALE_W-1:0];
                REG_INTEG_LIMIT: integ_limit_reg <= cfg_wdata[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rd_data_reg <= mem[s_addr];
        end
        if (wr_en) begin
            mem[addr_reg] <= {count_reg, sum_reg, err_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                rd_valid_reg <= valid_reg[s_addr];
            end
            if (wr_en) begin
                valid_reg[addr_reg] <= 1'b1;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_tvalid) state_next = in_range ? ST_LOAD : ST_OUT;
            ST_LOAD:  state_next = ST_MSPD;
            ST_MSPD:  state_next = ST_SPD;
            ST_SPD:   state_next = ST_ERR;
            ST_ERR:   state_next = ST_SUM;
            ST_SUM:   state_next = ST_KP;
            ST_KP:    state_next = ST_KD;
            ST_KD:    state_next = ST_CLAMP;
            ST_CLAMP: if (!div_status.busy) state_next = ST_KI0;
            ST_KI0:   state_next = ST_KI1;
            ST_KI1:   state_next = ST_KIH;
            ST_KIH:   state_next = ST_WB;
            ST_WB:    state_next = ST_OUT;
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MSPD: begin
                mul_a = MUL_W'($signed(diff));
                mul_b = MUL_W'(speed_scale_reg);
            end
            ST_SUM: begin
                mul_a = MUL_W'(err_reg);
                mul_b = MUL_W'(prop_gain_reg);
            end
            ST_KP: begin
                mul_a = derr;
                mul_b = MUL_W'(deriv_gain_reg);
            end
            ST_KI0: begin
                mul_a = MUL_W'(sum_reg[SPLIT-1:0]);
                mul_b = MUL_W'(integ_gain_reg);
            end
            ST_KI1: begin
                mul_a = MUL_W'($signed(sum_reg[SUM_W-1:SPLIT]));
                mul_b = MUL_W'(integ_gain_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                wheel_reg  <= s_tuser;
                addr_reg   <= s_addr;
                count_reg  <= s_tdata[DATA_W-1:0];
                target_reg <= s_tdata[TDATA_W-1:DATA_W];
                speed_reg  <= '0;
                drive_reg  <= '0;
            end
            ST_LOAD: begin
                if (rd_valid_reg) begin
                    pc_reg <= rd_data_reg[ENTRY_W-1 -: DATA_W];
                    es_reg <= rd_data_reg[DATA_W +: SUM_W];
                    pe_reg <= rd_data_reg[DATA_W-1:0];
                end else begin
                    pc_reg <= '0;
                    es_reg <= '0;
                    pe_reg <= '0;
                end
            end
            ST_SPD:   speed_reg <= sat32($signed(prod_reg[63:0]) >>> SPD_SH);
            ST_ERR:   err_reg   <= sat32(64'(err_wide));
            ST_SUM:   sum_reg   <= sat48(sum_wide);
            ST_KP:    acc_reg   <= $signed(prod_reg[ACC_W-1:0]);
            ST_KD:    acc_reg   <= acc_reg + $signed(prod_reg[ACC_W-1:0]);
            ST_CLAMP: begin
                if (!div_status.busy && (integ_gain_reg != '0)) begin
                    if (sum_x >= thr_x) begin
                        sum_reg <= q_x[SUM_W-1:0];
                    end else if (sum_x <= -thr_x) begin
                        sum_reg <= SUM_W'(-q_x);
                    end
                end
            end
            ST_KI1:   acc_reg   <= acc_reg + $signed(prod_reg[ACC_W-1:0]);
            ST_KIH:   acc_reg   <= acc_reg + $signed({prod_reg[ACC_W-SPLIT-1:0], {SPLIT{1'b0}}});
            ST_WB:    drive_reg <= sat32(64'(acc_reg >>> FRAC_GAIN));
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {speed_reg, drive_reg};
            m_tuser_reg <= wheel_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: hdl/wpid_chk.sv
module wpid_chk #(
    parameter int NUM_WHEELS = wpid_pkg::NUM_WHEELS_DEF
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [wpid_pkg::TDATA_W-1:0]    m_tdata,   // drive, measured_speed
    input logic [wpid_pkg::WHEEL_W-1:0]    m_tuser    // wheel_out
);
    import wpid_pkg::*;

    localparam int WEXT_W = 5;
    localparam logic [WEXT_W-1:0] WHEEL_CNT = WEXT_W'(NUM_WHEELS);

    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> s_tready && !m_tvalid)
        else $error("ports not idle after reset");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input still ready right after an accepted item");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    a_no_wheel_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (WEXT_W'(m_tuser) >= WHEEL_CNT) |-> (m_tdata == '0))
        else $error("nonzero result for absent wheel");

endmodule

bind wheel_speed_pid_unit wpid_chk #(.NUM_WHEELS(NUM_WHEELS)) u_wpid_chk (.*);

// File: test/wheel_speed_pid_unit_tb.sv
`timescale 1ns / 1ps

module wheel_speed_pid_unit_tb;
    import wpid_pkg::*;

    localparam int NUM_WHEELS = NUM_WHEELS_DEF;
    localparam int LIMIT_CYCLES = 1_200_000;
    localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_LO = -SUM_HI - 1;

    typedef struct packed {
        bit [WHEEL_W-1:0] wheel;
        bit [DATA_W-1:0]  drive;
        bit [DATA_W-1:0]  speed;
    } tick_result_t;

    class drive_scoreboard;
        longint kp, ki, kd, scale, limit;
        bit [DATA_W-1:0] last_count [NUM_WHEELS];
        longint err_sum [NUM_WHEELS];
        longint last_err [NUM_WHEELS];
        tick_result_t drive_due [$];
        int errors;

        function new();
            kp = longint'(PROP_GAIN_RST);
            ki = longint'(INTEG_GAIN_RST);
            kd = longint'(DERIV_GAIN_RST);
            scale = longint'(SPEED_SCALE_RST);
            limit = longint'(INTEG_LIMIT_RST);
            for (int k = 0; k < NUM_WHEELS; k++) begin
                last_count[k] = '0;
                err_sum[k] = 0;
                last_err[k] = 0;
            end
            errors = 0;
        endfunction

        function longint clip32(longint x);
            if (x > 64'sd2147483647) return 64'sd2147483647;
            if (x < -64'sd2147483648) return -64'sd2147483648;
            return x;
        endfunction

        function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
            case (idx)
                REG_PROP_GAIN:   kp = longint'(val[GAIN_W-1:0]);
                REG_INTEG_GAIN:  ki = longint'(val[GAIN_W-1:0]);
                REG_DERIV_GAIN:  kd = longint'(val[GAIN_W-1:0]);
                REG_SPEED_SCALE: scale = longint'(val[SCALE_W-1:0]);
                REG_INTEG_LIMIT: limit = longint'(val[LIM_W-1:0]);
                default: ;
            endcase
        endfunction

        function void note_tick(bit [WHEEL_W-1:0] w, bit [DATA_W-1:0] cnt,
                                bit [DATA_W-1:0] tgt);
            int di, ti;
            longint spd, err, sum, lim, thr, acc;
            tick_result_t r;
            r.wheel = w;
            if (w >= NUM_WHEELS) begin
                r.drive = '0;
                r.speed = '0;
                drive_due.push_back(r);
                return;
            end
            di = cnt - last_count[w];
            ti = tgt;
            spd = clip32((longint'(di) * scale) >>> 8);
            err = clip32(longint'(ti) - spd);
            sum = err_sum[w] + err;
            if (sum > SUM_HI) sum = SUM_HI;
            else if (sum < SUM_LO) sum = SUM_LO;
            if (ki != 0) begin
                lim = limit << FRAC_GAIN;
                thr = (lim + ki - 1) / ki;
                if (sum >= thr) sum = lim / ki;
                else if (sum <= -thr) sum = -(lim / ki);
            end
            err_sum[w] = sum;
            acc = kp * err + ki * sum + kd * (err - last_err[w]);
            last_err[w] = err;
            last_count[w] = cnt;
            r.drive = DATA_W'(clip32(acc >>> FRAC_GAIN));
            r.speed = DATA_W'(spd);
            drive_due.push_back(r);
        endfunction

        function void check_result(bit [WHEEL_W-1:0] w, bit [TDATA_W-1:0] data);
            tick_result_t want;
            if (drive_due.size() == 0) begin
                $display("%0t: result with nothing pending: wheel %0d drive %h speed %h",
                         $time, w, data[DATA_W-1:0], data[TDATA_W-1:DATA_W]);
                errors++;
                return;
            end
            want = drive_due.pop_front();
            if (w !== want.wheel) begin
                $display("%0t: wheel_out mismatch: expected %0d, actual %0d",
                         $time, want.wheel, w);
                errors++;
            end
            if (data[DATA_W-1:0] !== want.drive) begin
                $display("%0t: drive mismatch: expected %h, actual %h",
                         $time, want.drive, data[DATA_W-1:0]);
                errors++;
            end
            if (data[TDATA_W-1:DATA_W] !== want.speed) begin
                $display("%0t: measured_speed mismatch: expected %h, actual %h",
                         $time, want.speed, data[TDATA_W-1:DATA_W]);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [TDATA_W-1:0]    s_tdata;
    logic [WHEEL_W-1:0]    s_tuser;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [TDATA_W-1:0]    m_tdata;
    logic [WHEEL_W-1:0]    m_tuser;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    drive_scoreboard sb = new();
    bit [DATA_W-1:0] enc_pos [NUM_WHEELS];
    int unsigned rx_left = 0;
    int unsigned rx_stall_max = 0;
    int unsigned cycles = 0;

    wheel_speed_pid_unit #(
        .NUM_WHEELS(NUM_WHEELS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT_CYCLES) begin
            $display("wheel_speed_pid_unit_tb: done, errors");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata);
        if (rx_left != 0) begin
            rx_left--;
        end else if (rx_stall_max == 0 || !m_tready) begin
            m_tready <= 1'b1;
            rx_left = $urandom_range(1, 24);
        end else begin
            m_tready <= 1'b0;
            rx_left = $urandom_range(0, rx_stall_max);
        end
    end

    task automatic send_tick(bit [WHEEL_W-1:0] w, bit [DATA_W-1:0] cnt,
                             bit [DATA_W-1:0] tgt);
        s_tvalid <= 1'b1;
        s_tuser <= w;
        s_tdata <= {tgt, cnt};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sb.note_tick(w, cnt, tgt);
        enc_pos[w] = cnt;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.drive_due.size() != 0);
    endtask

    task automatic write_reg_port(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    task automatic apply_config(bit [GAIN_W-1:0] p, i, d, bit [SCALE_W-1:0] sc,
                                bit [LIM_W-1:0] lm);
        write_reg_port(REG_PROP_GAIN, {8'($urandom), p});
        write_reg_port(REG_INTEG_GAIN, {8'($urandom), i});
        write_reg_port(REG_DERIV_GAIN, {8'($urandom), d});
        write_reg_port(REG_SPEED_SCALE, sc);
        write_reg_port(REG_INTEG_LIMIT, {1'($urandom), lm});
        write_reg_port(REG_INTEG_LIMIT + CFG_IDX_W'(1 + $urandom_range(0, 2)), $urandom);
        cfg_we <= 1'b0;
    endtask

    task automatic send_random(int unsigned n, int unsigned gap_max);
        int unsigned left, k, spread;
        bit [WHEEL_W-1:0] w;
        bit [DATA_W-1:0] cnt, tgt;
        left = 0;
        for (k = 0; k < n; k++) begin
            if (left == 0) begin
                left = $urandom_range(1, 30);
                if ($urandom_range(0, 99) == 0) begin
                    wait_drained();
                end else if (gap_max != 0 && $urandom_range(0, 3) != 0) begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, gap_max)) @(posedge aclk);
                end
            end
            left--;
            w = WHEEL_W'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0, 1: begin
                    cnt = $urandom;
                    tgt = $urandom;
                end
                2: begin
                    cnt = enc_pos[w] + $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
                    tgt = $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
                end
                default: begin
                    spread = ($urandom_range(0, 1) != 0) ? 4 : 64;
                    cnt = enc_pos[w] + $urandom_range(0, 2 * spread) - spread;
                    tgt = $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
                end
            endcase
            send_tick(w, cnt, tgt);
        end
    endtask

    task automatic run_phase(bit [GAIN_W-1:0] p, i, d, bit [SCALE_W-1:0] sc,
                             bit [LIM_W-1:0] lm, int unsigned n, gap_max, stall_max);
        wait_drained();
        repeat (8) @(posedge aclk);
        apply_config(p, i, d, sc, lm);
        rx_stall_max = stall_max;
        send_random(n, gap_max);
    endtask

    initial begin
        aresetn <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        for (int k = 0; k < NUM_WHEELS; k++) enc_pos[k] = '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_tick(0, 32'h0000_0000, 32'h0000_0000);
        send_tick(0, 32'h7FFF_FFFF, 32'h0000_0000);
        send_tick(0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_tick(1, 32'h8000_0000, 32'h8000_0000);
        send_tick(1, 32'h7FFF_FFFF, 32'h8000_0000);
        send_tick(1, 32'h0000_0000, 32'h7FFF_FFFF);
        send_tick(2, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        send_tick(2, 32'h0000_0000, 32'h7FFF_FFFF);
        send_tick(2, 32'h0000_0000, 32'h7FFF_FFFF);
        send_tick(3, 32'h8000_0001, 32'h8000_0000);
        send_tick(3, 32'h8000_0001, 32'h8000_0000);
        send_tick(3, 32'h8000_0001, 32'h0000_0000);
        send_tick(0, 32'h8000_0010, 32'h0001_0000);
        send_tick(1, 32'h5555_5555, 32'hAAAA_AAAA);
        send_tick(1, 32'hAAAA_AAAA, 32'h5555_5555);
        send_tick(2, 32'h0000_0005, 32'h0000_0000);
        send_tick(3, 32'h7FFF_FFFF, 32'h7FFF_FFFF);

        rx_stall_max = 10;
        send_random(200, 20);

        run_phase(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF,
                  200, 0, 0);
        run_phase(0, 0, 0, 0, 0, 150, 40, 30);
        run_phase(GAIN_W'($urandom_range(0, 24'hFF_FFFF)), 0,
                  GAIN_W'($urandom_range(0, 24'hFF_FFFF)),
                  $urandom, LIM_W'($urandom_range(0, 32'h7FFF_FFFF)), 250, 10, 60);
        run_phase(GAIN_W'($urandom_range(0, 24'hFF_FFFF)),
                  GAIN_W'($urandom_range(1, 24'hFF_FFFF)),
                  GAIN_W'($urandom_range(0, 24'hFF_FFFF)), $urandom, 0, 200, 5, 5);
        run_phase(PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST, SPEED_SCALE_RST,
                  INTEG_LIMIT_RST, 250, 60, 0);
        run_phase(1, 1, 0, 32'h0100_0000, 31'h7FFF_FFFF, 150, 0, 40);
        repeat (3) begin
            run_phase(GAIN_W'($urandom_range(0, 24'hFF_FFFF)),
                      GAIN_W'($urandom_range(0, 24'h0F_FFFF)),
                      GAIN_W'($urandom_range(0, 24'h00_FFFF)),
                      $urandom_range(0, 32'h0FFF_FFFF),
                      LIM_W'($urandom_range(0, 32'h0FFF_FFFF)), 200,
                      $urandom_range(0, 50), $urandom_range(0, 50));
        end

        wait_drained();
        repeat (60) @(posedge aclk);
        if (sb.errors == 0 && sb.drive_due.size() == 0)
            $display("wheel_speed_pid_unit_tb: done, clean");
        else
            $display("wheel_speed_pid_unit_tb: done, errors");
        $finish;
    end

endmodule
